// ===== src/plate_gravity_accumulator_unit_assert.svh =====
// assertion macros for the plate gravity accumulator
`ifndef PLATE_GRAVITY_ACCUMULATOR_UNIT_ASSERT_SVH
`define PLATE_GRAVITY_ACCUMULATOR_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// consequent must hold in the same cycle as the antecedent
`define PGA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pga assertion failed");
// consequent must hold in the cycle after the antecedent
`define PGA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pga assertion failed");
`else
`define PGA_ASSERT_SAME(label, clk, rst, ante, cons)
`define PGA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== src/pga_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package pga_pkg;

   // fixed widths of the arithmetic
   localparam int UNIT_BITS = 28;
   localparam int R_W       = 33;              // root and |d|
   localparam int SQ_W      = 2 * R_W;         // sum of squares
   localparam int DIV_W     = R_W + UNIT_BITS; // dividend magnitude
   localparam int E_W       = 30;              // unit vector component
   localparam int Q_W       = 36;              // n.e after shift
   localparam int T_W       = 36;              // tangential term
   localparam int MUL_W     = 36;              // multiplier operand
   localparam int ACC_W     = 64;
   localparam int OUT_W     = 48;

   // register indexes
   localparam logic [1:0] CSR_FIELD_X = 2'd0;
   localparam logic [1:0] CSR_FIELD_Y = 2'd1;
   localparam logic [1:0] CSR_FIELD_Z = 2'd2;

   typedef struct packed {
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [31:0] center_z;
      logic signed [31:0] normal_x;
      logic signed [31:0] normal_y;
      logic signed [31:0] normal_z;
      logic               last_plate;
   } pga_req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] potential;
      logic signed [OUT_W-1:0] accel_x;
      logic signed [OUT_W-1:0] accel_y;
      logic signed [OUT_W-1:0] accel_z;
   } pga_rsp_type;

   typedef enum logic [1:0] {
      MUL_SQ,
      MUL_NE,
      MUL_EQ
   } pga_mul_sel_type;

   typedef enum logic {
      DIV_E,
      DIV_A
   } pga_div_sel_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SQ_MUL,
      S_SQ_ACC,
      S_SQRT_GO,
      S_SQRT_WAIT,
      S_E_GO,
      S_E_WAIT,
      S_DOT_MUL,
      S_DOT_ACC,
      S_Q,
      S_EQ_MUL,
      S_T,
      S_A_GO,
      S_A_WAIT,
      S_FINISH
   } pga_state_type;

   typedef struct packed {
      logic            load;
      logic [1:0]      idx;
      pga_mul_sel_type mul_sel;
      logic            sq_acc;
      logic            sqrt_start;
      logic            div_start;
      pga_div_sel_type div_sel;
      logic            e_store;
      logic            ne_acc;
      logic            q_store;
      logic            t_store;
      logic            a_acc;
      logic            emit;
   } pga_cmd_type;

   typedef struct packed {
      logic sqrt_done;
      logic r_zero;
      logic div_done;
      logic last;
      logic out_free;
   } pga_status_type;

endpackage
`default_nettype wire

// ===== src/pga_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pga_sqrt
   import pga_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire logic [SQ_W-1:0] radicand,
   output logic                 done,
   output logic [R_W-1:0]       root
);

   localparam int CNT_W = $clog2(R_W + 1);

   logic [SQ_W-1:0]  rad_ff, rad_in;
   logic [R_W+1:0]   rem_ff, rem_in;
   logic [R_W-1:0]   root_ff, root_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [R_W+3:0]   rem_sh;
   logic [R_W+3:0]   trial;

   // one root bit per cycle, two radicand bits shifted in
   always_comb begin
      rem_sh  = {rem_ff, rad_ff[SQ_W-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(R_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[SQ_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = (R_W+2)'(rem_sh - trial);
            root_in = {root_ff[R_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[R_W+1:0];
            root_in = {root_ff[R_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
`default_nettype wire

// ===== src/pga_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pga_div
   import pga_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DIV_W-1:0] dividend,
   input  wire logic [R_W-1:0]   divisor,
   output logic                  done,
   output logic [DIV_W-1:0]      quotient
);

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [R_W-1:0]   rem_ff, rem_in;
   logic [R_W-1:0]   dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [R_W:0]     trial;

   // restoring division, one quotient bit per cycle
   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = R_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[R_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// ===== src/pga_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pga_datapath
   import pga_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire pga_cmd_type cmd,
   output pga_status_type   status,
   input  wire pga_req_type req_payload,
   input  wire logic        csr_valid,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output pga_rsp_type      rsp_payload
);

   // saturating 64-bit add
   function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                       input logic signed [ACC_W-1:0] b);
      logic [ACC_W:0] s;
      s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
      if (s[ACC_W] != s[ACC_W-1])
         sat_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      else
         sat_add = s[ACC_W-1:0];
   endfunction

   // quarter of a sum, saturated to the result width
   function automatic logic signed [OUT_W-1:0] out_sat(input logic signed [ACC_W-1:0] sum);
      logic signed [ACC_W-1:0] v;
      v = sum >>> 2;
      if (v[ACC_W-1:OUT_W-1] != {(ACC_W-OUT_W+1){v[ACC_W-1]}})
         out_sat = v[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
      else
         out_sat = v[OUT_W-1:0];
   endfunction

   logic signed [31:0]        field_ff [3];
   logic signed [R_W-1:0]     d_ff [3];
   logic signed [31:0]        n_ff [3];
   logic signed [E_W-1:0]     e_ff [3];
   logic                      last_ff;
   logic [SQ_W-1:0]           s_ff;
   logic [R_W-1:0]            r_ff;
   logic signed [ACC_W-1:0]   ne_ff;
   logic signed [Q_W-1:0]     q_ff;
   logic signed [T_W-1:0]     t_ff;
   logic signed [2*MUL_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]   pot_ff;
   logic signed [ACC_W-1:0]   acc_ff [3];
   pga_rsp_type               rsp_ff;
   logic                      rsp_valid_ff;

   logic [R_W-1:0]          d_mag;
   logic [T_W-1:0]          t_mag;
   logic signed [MUL_W-1:0] op_a, op_b;
   logic [DIV_W-1:0]        div_num;
   logic                    div_neg;
   logic                    sqrt_done, div_done;
   logic [R_W-1:0]          root;
   logic [DIV_W-1:0]        quo;
   logic signed [E_W-1:0]   e_mag;
   logic signed [ACC_W-1:0] a_val;

   // magnitudes of the selected lane
   assign d_mag = d_ff[cmd.idx][R_W-1] ? R_W'(-d_ff[cmd.idx]) : R_W'(d_ff[cmd.idx]);
   assign t_mag = t_ff[T_W-1] ? T_W'(-t_ff) : T_W'(t_ff);

   // shared multiplier operand select
   always_comb begin
      case (cmd.mul_sel)
         MUL_SQ: begin
            op_a = $signed(MUL_W'(d_mag));
            op_b = $signed(MUL_W'(d_mag));
         end
         MUL_NE: begin
            op_a = MUL_W'(n_ff[cmd.idx]);
            op_b = MUL_W'(e_ff[cmd.idx]);
         end
         MUL_EQ: begin
            op_a = MUL_W'(e_ff[cmd.idx]);
            op_b = q_ff;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end
   assign prod_in = op_a * op_b;

   // divider operand select
   always_comb begin
      case (cmd.div_sel)
         DIV_E: begin
            div_num = {d_mag, {UNIT_BITS{1'b0}}};
            div_neg = d_ff[cmd.idx][R_W-1];
         end
         DIV_A: begin
            div_num = DIV_W'(t_mag) << FRAC_BITS;
            div_neg = t_ff[T_W-1];
         end
         default: begin
            div_num = '0;
            div_neg = 1'b0;
         end
      endcase
   end

   pga_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.sqrt_start),
      .radicand (s_ff),
      .done     (sqrt_done),
      .root     (root)
   );

   pga_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_num),
      .divisor  (r_ff),
      .done     (div_done),
      .quotient (quo)
   );

   // signed quotients: unit vector, and the negated acceleration term
   assign e_mag = $signed(quo[E_W-1:0]);
   assign a_val = div_neg ? $signed(ACC_W'(quo)) : -$signed(ACC_W'(quo));

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         field_ff[0] <= '0;
         field_ff[1] <= '0;
         field_ff[2] <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FIELD_X: field_ff[0] <= csr_data;
            CSR_FIELD_Y: field_ff[1] <= csr_data;
            CSR_FIELD_Z: field_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   // per-plate working registers
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (cmd.load) begin
         d_ff[0] <= R_W'(field_ff[0]) - R_W'(req_payload.center_x);
         d_ff[1] <= R_W'(field_ff[1]) - R_W'(req_payload.center_y);
         d_ff[2] <= R_W'(field_ff[2]) - R_W'(req_payload.center_z);
         n_ff[0] <= req_payload.normal_x;
         n_ff[1] <= req_payload.normal_y;
         n_ff[2] <= req_payload.normal_z;
         last_ff <= req_payload.last_plate;
         s_ff    <= '0;
         ne_ff   <= '0;
      end
      if (cmd.sq_acc)
         s_ff <= s_ff + prod_ff[SQ_W-1:0];
      if (sqrt_done)
         r_ff <= root;
      if (cmd.e_store)
         e_ff[cmd.idx] <= div_neg ? -e_mag : e_mag;
      if (cmd.ne_acc)
         ne_ff <= ne_ff + prod_ff[ACC_W-1:0];
      if (cmd.q_store)
         q_ff <= ne_ff[ACC_W-1:UNIT_BITS];
      if (cmd.t_store)
         t_ff <= T_W'(n_ff[cmd.idx]) - prod_ff[UNIT_BITS+T_W-1:UNIT_BITS];
   end

   // accumulators and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         pot_ff       <= '0;
         acc_ff[0]    <= '0;
         acc_ff[1]    <= '0;
         acc_ff[2]    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.q_store)
            pot_ff <= sat_add(pot_ff, ne_ff >>> UNIT_BITS);
         if (cmd.a_acc)
            acc_ff[cmd.idx] <= sat_add(acc_ff[cmd.idx], a_val);
         if (cmd.emit) begin
            pot_ff       <= '0;
            acc_ff[0]    <= '0;
            acc_ff[1]    <= '0;
            acc_ff[2]    <= '0;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (cmd.emit) begin
         rsp_ff.potential <= out_sat(pot_ff);
         rsp_ff.accel_x   <= out_sat(acc_ff[0]);
         rsp_ff.accel_y   <= out_sat(acc_ff[1]);
         rsp_ff.accel_z   <= out_sat(acc_ff[2]);
      end
   end

   assign status.sqrt_done = sqrt_done;
   assign status.r_zero    = (root == '0);
   assign status.div_done  = div_done;
   assign status.last      = last_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

// ===== src/pga_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pga_ctrl
   import pga_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire pga_status_type status,
   output pga_cmd_type         cmd
);

   pga_state_type state_ff, state_in;
   logic [1:0]    idx_ff, idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   // sequencing of one request
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      req_ready   = 1'b0;
      cmd         = '0;
      cmd.idx     = idx_ff;
      cmd.mul_sel = MUL_SQ;
      cmd.div_sel = DIV_E;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               idx_in   = '0;
               state_in = S_SQ_MUL;
            end
         end
         S_SQ_MUL: begin
            cmd.mul_sel = MUL_SQ;
            state_in    = S_SQ_ACC;
         end
         S_SQ_ACC: begin
            cmd.sq_acc = 1'b1;
            if (idx_ff == 2'd2) begin
               state_in = S_SQRT_GO;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_SQ_MUL;
            end
         end
         S_SQRT_GO: begin
            cmd.sqrt_start = 1'b1;
            state_in       = S_SQRT_WAIT;
         end
         S_SQRT_WAIT: begin
            if (status.sqrt_done) begin
               idx_in   = '0;
               state_in = status.r_zero ? S_FINISH : S_E_GO;
            end
         end
         S_E_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_E;
            state_in      = S_E_WAIT;
         end
         S_E_WAIT: begin
            cmd.div_sel = DIV_E;
            if (status.div_done) begin
               cmd.e_store = 1'b1;
               if (idx_ff == 2'd2) begin
                  idx_in   = '0;
                  state_in = S_DOT_MUL;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_E_GO;
               end
            end
         end
         S_DOT_MUL: begin
            cmd.mul_sel = MUL_NE;
            state_in    = S_DOT_ACC;
         end
         S_DOT_ACC: begin
            cmd.ne_acc = 1'b1;
            if (idx_ff == 2'd2) begin
               idx_in   = '0;
               state_in = S_Q;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_DOT_MUL;
            end
         end
         S_Q: begin
            cmd.q_store = 1'b1;
            state_in    = S_EQ_MUL;
         end
         S_EQ_MUL: begin
            cmd.mul_sel = MUL_EQ;
            state_in    = S_T;
         end
         S_T: begin
            cmd.t_store = 1'b1;
            state_in    = S_A_GO;
         end
         S_A_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_A;
            state_in      = S_A_WAIT;
         end
         S_A_WAIT: begin
            cmd.div_sel = DIV_A;
            if (status.div_done) begin
               cmd.a_acc = 1'b1;
               if (idx_ff == 2'd2) begin
                  state_in = S_FINISH;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_EQ_MUL;
               end
            end
         end
         S_FINISH: begin
            // last plate waits for a free result slot
            if (!status.last) begin
               state_in = S_IDLE;
            end else if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== src/plate_gravity_accumulator_unit.sv =====
// one plate at a time: each request runs six divisions on the shared divider and a
// square root before the next is accepted; a plate whose center is the field point
// skips the divisions. a last plate's result is held back while an earlier result waits.
// synchronous active-high reset clears the sums, field point and control.
`timescale 1ns / 1ps
`default_nettype none
`include "plate_gravity_accumulator_unit_assert.svh"
module plate_gravity_accumulator_unit
   import pga_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire pga_req_type req_payload,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output pga_rsp_type      rsp_payload,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   pga_cmd_type    cmd;
   pga_status_type status;

   assign csr_ready = 1'b1;

   // sequencer
   pga_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic and result register
   pga_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // a request leaves the block busy in the cycle after it is accepted
   `PGA_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   // a result is only loaded into a free slot
   `PGA_ASSERT_SAME(a_emit_free, clock, reset, cmd.emit, !rsp_valid || rsp_ready)
   // the divider only finishes while a request is in progress
   `PGA_ASSERT_SAME(a_div_busy, clock, reset, status.div_done, !req_ready)

endmodule
`default_nettype wire

// ===== sim/plate_gravity_accumulator_unit_tb.sv =====
`timescale 1ns / 1ps
module plate_gravity_accumulator_unit_tb;
   import pga_pkg::*;

   localparam int FRAC_BITS = 16;
   localparam int DRAIN_CYCLES = 600;
   localparam logic [1:0] CSR_UNMAPPED = 2'd3;
   localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] MIN32 = 32'sh8000_0000;
   localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;
   localparam longint MAX64 = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint MIN64 = 64'sh8000_0000_0000_0000;

   typedef struct {
      pga_req_type plate;
      bit          typed;
      pga_rsp_type want;
   } plate_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   pga_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   pga_rsp_type rsp_payload;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   // field point and running sums of the predictor
   longint      field_pt [3];
   longint      pot_sum;
   longint      accel_sum [3];
   pga_rsp_type gravity_queue [$];
   plate_row_type plate_table [$];
   int          mismatches = 0;
   bit          idle_on = 1'b1;
   int          sent = 0;

   plate_gravity_accumulator_unit #(.FRAC_BITS(FRAC_BITS)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic longint sat_sum(input longint a, input longint b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > 65'(MAX64)) return MAX64;
      if (s < 65'(MIN64)) return MIN64;
      return longint'(s);
   endfunction

   function automatic logic signed [47:0] quarter_sat(input longint v);
      longint q;
      q = v >>> 2;
      if (q > longint'(MAX48)) return MAX48;
      if (q < longint'(MIN48)) return MIN48;
      return q[47:0];
   endfunction

   // plate-center gravity terms, exact integer arithmetic
   function automatic bit gravity_step(input pga_req_type p, output pga_rsp_type res);
      longint d [3];
      longint n [3];
      longint e [3];
      longint mag, rs, ne, q, t, a;
      logic [67:0] sq;
      logic [32:0] root, cand;
      sq = '0;
      d[0] = field_pt[0] - longint'(p.center_x);
      d[1] = field_pt[1] - longint'(p.center_y);
      d[2] = field_pt[2] - longint'(p.center_z);
      n[0] = p.normal_x;
      n[1] = p.normal_y;
      n[2] = p.normal_z;
      for (int i = 0; i < 3; i++) begin
         mag = d[i] < 0 ? -d[i] : d[i];
         sq += 68'(mag) * 68'(mag);
      end
      root = '0;
      for (int b = 32; b >= 0; b--) begin
         cand = root | (33'd1 << b);
         if (68'(cand) * 68'(cand) <= sq) root = cand;
      end
      rs = longint'({31'b0, root});
      if (rs != 0) begin
         ne = 0;
         for (int i = 0; i < 3; i++) begin
            e[i] = (d[i] * (longint'(1) <<< UNIT_BITS)) / rs;
            ne += n[i] * e[i];
         end
         q = ne >>> UNIT_BITS;
         pot_sum = sat_sum(pot_sum, q);
         for (int i = 0; i < 3; i++) begin
            t = n[i] - ((e[i] * q) >>> UNIT_BITS);
            a = (t * (longint'(1) <<< FRAC_BITS)) / rs;
            accel_sum[i] = sat_sum(accel_sum[i], -a);
         end
      end
      res = '0;
      if (!p.last_plate) return 1'b0;
      res.potential = quarter_sat(pot_sum);
      res.accel_x = quarter_sat(accel_sum[0]);
      res.accel_y = quarter_sat(accel_sum[1]);
      res.accel_z = quarter_sat(accel_sum[2]);
      pot_sum = 0;
      accel_sum = '{0, 0, 0};
      return 1'b1;
   endfunction

   // stall bursts on the result side
   initial begin
      int n;
      @(negedge reset);
      forever begin
         if (idle_on && $urandom_range(0, 2) == 0) begin
            n = $urandom_range(1, 15);
            rsp_ready <= 1'b0;
         end else begin
            n = $urandom_range(1, 20);
            rsp_ready <= 1'b1;
         end
         repeat (n) @(posedge clock);
      end
   end

   // result checking against the oldest prediction
   always @(posedge clock) begin
      pga_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (gravity_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", rsp_payload);
         end else begin
            want = gravity_queue.pop_front();
            if (want.potential !== rsp_payload.potential || want.accel_x !== rsp_payload.accel_x
                || want.accel_y !== rsp_payload.accel_y || want.accel_z !== rsp_payload.accel_z)
            begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p actual %p", want, rsp_payload);
            end
         end
      end
   end

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_FIELD_X: field_pt[0] = longint'(signed'(val));
         CSR_FIELD_Y: field_pt[1] = longint'(signed'(val));
         CSR_FIELD_Z: field_pt[2] = longint'(signed'(val));
         default: ;
      endcase
   endtask

   // send one request; a typed row overrides the predicted result
   task automatic send_plate(input pga_req_type p, input bit typed, input pga_rsp_type want);
      pga_rsp_type res;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
      if (gravity_step(p, res))
         gravity_queue.insert(gravity_queue.size(), typed ? want : res);
   endtask

   // wait for all results, then let any trailing plate finish
   task automatic settle();
      req_valid <= 1'b0;
      while (gravity_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic add_row(input logic [31:0] cx, cy, cz, nx, ny, nz, input bit last,
                          input bit typed, input pga_rsp_type want);
      plate_row_type row;
      row.plate = '{cx, cy, cz, nx, ny, nz, last};
      row.typed = typed;
      row.want = want;
      plate_table.insert(plate_table.size(), row);
   endtask

   function automatic logic [31:0] near(input longint base);
      longint v;
      v = base + longint'($signed($urandom_range(0, 64))) - 32;
      if (v > longint'(MAX32)) v = MAX32;
      if (v < longint'(MIN32)) v = MIN32;
      return v[31:0];
   endfunction

   function automatic logic [31:0] rand_coord(input longint base);
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return near(base);
         2: return base[31:0] + $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
         default: return base[31:0] + ($urandom & 32'h0FFF_FFFF) - 32'h0800_0000;
      endcase
   endfunction

   function automatic logic [31:0] rand_normal();
      return $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
   endfunction

   function automatic logic [31:0] rand_field();
      case ($urandom_range(0, 4))
         0: return MAX32;
         1: return MIN32;
         2: return 32'h0;
         default: return $urandom;
      endcase
   endfunction

   // stimulus
   initial begin
      pga_req_type p;
      pga_rsp_type none;
      int plates;
      int phase;
      none = '0;
      field_pt = '{0, 0, 0};
      pot_sum = 0;
      accel_sum = '{0, 0, 0};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows at the reset field point
      add_row(0, 0, 0, MAX32, MIN32, MAX32, 1'b1, 1'b1, '{48'sd0, 48'sd0, 48'sd0, 48'sd0});
      add_row(MAX32, MAX32, MAX32, MAX32, MAX32, MAX32, 1'b0, 1'b0, none);
      add_row(MIN32, MIN32, MIN32, MIN32, MIN32, MIN32, 1'b1, 1'b0, none);
      add_row(MAX32, MIN32, 0, MIN32, MAX32, 1, 1'b1, 1'b0, none);
      for (int i = 0; i < 5; i++)
         add_row(-1, 0, 0, 0, MIN32, 0, i == 4, i == 4, '{48'sd0, 48'sd0, MAX48, 48'sd0});
      for (int i = 0; i < 5; i++)
         add_row(-1, 0, 0, 0, MAX32, 0, i == 4, i == 4, '{48'sd0, 48'sd0, MIN48, 48'sd0});
      add_row(0, 0, 0, 32'h0001_0000, 0, 0, 1'b0, 1'b0, none);
      add_row(32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 32'h0000_8000, 32'hFFFF_8000,
              32'h0001_0000, 1'b1, 1'b0, none);
      add_row(1, 1, 1, MIN32, MIN32, MIN32, 1'b0, 1'b0, none);
      add_row(-1, 0, 1, MAX32, 0, MIN32, 1'b1, 1'b0, none);
      foreach (plate_table[i])
         send_plate(plate_table[i].plate, plate_table[i].typed, plate_table[i].want);

      // random models under changing field points
      phase = 0;
      while (sent < 760) begin
         settle();
         if (sent > 650) idle_on = 1'b0;
         write_csr(CSR_UNMAPPED, $urandom);
         write_csr(CSR_FIELD_X, phase == 0 ? MAX32 : phase == 1 ? MIN32 : rand_field());
         write_csr(CSR_FIELD_Y, phase == 0 ? MAX32 : phase == 1 ? MIN32 : rand_field());
         write_csr(CSR_FIELD_Z, phase == 0 ? MIN32 : phase == 1 ? MAX32 : rand_field());
         for (int m = 0; m < 6; m++) begin
            plates = $urandom_range(1, 8);
            for (int k = 0; k < plates; k++) begin
               if ($urandom_range(0, 15) == 0) begin
                  p.center_x = 32'(field_pt[0]);
                  p.center_y = 32'(field_pt[1]);
                  p.center_z = 32'(field_pt[2]);
               end else begin
                  p.center_x = rand_coord(field_pt[0]);
                  p.center_y = rand_coord(field_pt[1]);
                  p.center_z = rand_coord(field_pt[2]);
               end
               p.normal_x = rand_normal();
               p.normal_y = rand_normal();
               p.normal_z = rand_normal();
               // mostly closed models, sometimes a stray unterminated run
               p.last_plate = (k == plates - 1) ? ($urandom_range(0, 9) != 0) : 1'b0;
               send_plate(p, 1'b0, none);
            end
         end
         // close any open model before the next field point
         p = '0;
         p.center_x = near(field_pt[0]);
         p.normal_z = $urandom;
         p.last_plate = 1'b1;
         send_plate(p, 1'b0, none);
         phase++;
      end

      settle();
      if (mismatches == 0 && gravity_queue.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
